>>> rtl/core/unsigned_to_ascii_digits_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef UNSIGNED_TO_ASCII_DIGITS_UNIT_MACROS_SVH
`define UNSIGNED_TO_ASCII_DIGITS_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define U2A_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define U2A_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/u2a_pkg.sv
`timescale 1ns / 1ps
package u2a_pkg;

	// Field widths
	localparam int VALUE_W  = 64;
	localparam int FORMAT_W = 2;
	localparam int CHAR_W   = 7;
	localparam int COUNT_W  = 5;

	// Conversion widths
	localparam int NARROW_WIDTH = 32;
	localparam int WIDE_WIDTH   = 64;
	localparam int MAX_OUT      = 16;

	// Digit counts: decimal digits of the largest narrow value, hex nibbles
	localparam int DEC_DIGITS  = (NARROW_WIDTH * 30103) / 100000 + 1;
	localparam int HEXN_DIGITS = (NARROW_WIDTH + 3) / 4;
	localparam int HEXW_DIGITS = (WIDE_WIDTH + 3) / 4;
	localparam int DIG_MAX0    = (DEC_DIGITS > HEXN_DIGITS) ? DEC_DIGITS : HEXN_DIGITS;
	localparam int DIG_MAX     = (DIG_MAX0 > HEXW_DIGITS) ? DIG_MAX0 : HEXW_DIGITS;
	localparam int DIG_BITS    = 4 * DIG_MAX;
	localparam int BCD_W       = 4 * DEC_DIGITS;
	localparam int HEXN_BITS   = 4 * HEXN_DIGITS;
	localparam int HEXW_BITS   = 4 * HEXW_DIGITS;
	localparam int LEFT_W      = $clog2(DIG_MAX + 1);
	localparam int CONV_CNT_W  = $clog2(NARROW_WIDTH + 1);

	// ASCII offsets
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] ALPHA_UP   = 7'd55;
	localparam logic [CHAR_W-1:0] ALPHA_LO   = 7'd87;
	localparam logic [3:0]        DIGIT_TEN  = 4'd10;

	typedef enum logic [FORMAT_W-1:0] {
		FMT_DEC    = 2'd0,
		FMT_HEX_UP = 2'd1,
		FMT_HEX_LO = 2'd2,
		FMT_HEX_LX = 2'd3
	} fmt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  character;
		logic               last;
		logic [COUNT_W-1:0] digit_count;
	} result_t;

	// Map one digit to its ASCII character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic lower);
		logic [CHAR_W-1:0] base;
		base = (d < DIGIT_TEN) ? ASCII_ZERO : (lower ? ALPHA_LO : ALPHA_UP);
		return base + CHAR_W'(d);
	endfunction

endpackage

>>> rtl/core/u2a_number_if.sv
`timescale 1ns / 1ps
interface u2a_number_if;
	logic                        valid;
	logic                        ready;
	logic [u2a_pkg::VALUE_W-1:0]  value;
	logic [u2a_pkg::FORMAT_W-1:0] format;

	modport source (output valid, output value, output format, input ready);
	modport sink (input valid, input value, input format, output ready);
endinterface

>>> rtl/core/u2a_digits_if.sv
`timescale 1ns / 1ps
interface u2a_digits_if;
	logic                        valid;
	logic                        ready;
	logic [u2a_pkg::CHAR_W-1:0]  character;
	logic                        last;
	logic [u2a_pkg::COUNT_W-1:0] digit_count;

	modport source (output valid, output character, output last, output digit_count,
		input ready);
	modport sink (input valid, input character, input last, input digit_count,
		output ready);
endinterface

>>> rtl/core/u2a_bcd_conv.sv
`timescale 1ns / 1ps
module u2a_bcd_conv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [u2a_pkg::NARROW_WIDTH-1:0]  value,
	output logic                              done,
	output logic [u2a_pkg::BCD_W-1:0]         bcd
);

	logic [u2a_pkg::NARROW_WIDTH-1:0] sh_q;
	logic [u2a_pkg::BCD_W-1:0]        bcd_q;
	logic [u2a_pkg::BCD_W-1:0]        adj;
	logic [u2a_pkg::CONV_CNT_W-1:0]   cnt_q;
	logic                             run_q;
	logic                             done_q;

	// Add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < u2a_pkg::DEC_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	// Advance one binary bit per cycle, most significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == u2a_pkg::CONV_CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= u2a_pkg::CONV_CNT_W'(u2a_pkg::NARROW_WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - u2a_pkg::CONV_CNT_W'(1);
				if (cnt_q == u2a_pkg::CONV_CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Shift the value out and the BCD word in
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= value;
			bcd_q <= '0;
		end else if (run_q) begin
			sh_q  <= sh_q << 1;
			bcd_q <= {adj[u2a_pkg::BCD_W-2:0], sh_q[u2a_pkg::NARROW_WIDTH-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

>>> rtl/core/u2a_out_reg.sv
`timescale 1ns / 1ps
module u2a_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  u2a_pkg::result_t   data,
	output logic               take,
	u2a_digits_if.source       digits
);

	logic             valid_q;
	u2a_pkg::result_t data_q;

	// Free when empty or when the held result transfers now
	assign take = !valid_q || digits.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= push;
		end
	end

	// Hold the payload until it transfers
	always_ff @(posedge clk) begin
		if (take && push) begin
			data_q <= data;
		end
	end

	assign digits.valid       = valid_q;
	assign digits.character   = data_q.character;
	assign digits.last        = data_q.last;
	assign digits.digit_count = data_q.digit_count;

endmodule

>>> rtl/core/unsigned_to_ascii_digits_unit.sv
// Hex items pass from the input transfer through the skip state to the output register;
//   decimal items first go through the bit-serial BCD converter, one input bit at a time,
//   most significant first. The digit shifter drops leading zero digits before emission.
// Throughput: one character per cycle while the output is not stalled; a new item is taken
//   only once the last character of the previous one is in the output register.
// Reset: arst_n clears the state machine and the valid flags; the payload is not reset.
`timescale 1ns / 1ps
module unsigned_to_ascii_digits_unit (
	input  logic        clk,
	input  logic        arst_n,
	u2a_number_if.sink  number,
	u2a_digits_if.source digits
);

	u2a_pkg::st_t state_q;
	u2a_pkg::st_t state_nx;

	logic [u2a_pkg::DIG_BITS-1:0] dig_q;
	logic [u2a_pkg::LEFT_W-1:0]   ndig_q;
	logic [u2a_pkg::COUNT_W-1:0]  left_q;
	logic [u2a_pkg::COUNT_W-1:0]  tot_q;
	logic                         lower_q;

	logic                         accept;
	logic                         conv_start;
	logic                         conv_done;
	logic [u2a_pkg::BCD_W-1:0]    bcd;
	logic                         skip_shift;
	logic                         push;
	logic                         take;
	logic [3:0]                   top_dig;
	logic [u2a_pkg::COUNT_W-1:0]  total;
	u2a_pkg::result_t             res;
	u2a_pkg::fmt_t                fmt;

	assign fmt     = u2a_pkg::fmt_t'(number.format);
	assign top_dig = dig_q[u2a_pkg::DIG_BITS-1 -: 4];
	assign total   = (int'(ndig_q) > u2a_pkg::MAX_OUT) ? u2a_pkg::COUNT_W'(u2a_pkg::MAX_OUT)
		: u2a_pkg::COUNT_W'(ndig_q);

	u2a_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  (number.value[u2a_pkg::NARROW_WIDTH-1:0]),
		.done   (conv_done),
		.bcd    (bcd)
	);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			u2a_pkg::ST_IDLE: begin
				if (number.valid) begin
					state_nx = (fmt == u2a_pkg::FMT_DEC) ? u2a_pkg::ST_CONV : u2a_pkg::ST_SKIP;
				end
			end
			u2a_pkg::ST_CONV: begin
				if (conv_done) begin
					state_nx = u2a_pkg::ST_SKIP;
				end
			end
			u2a_pkg::ST_SKIP: begin
				if (!skip_shift) begin
					state_nx = u2a_pkg::ST_EMIT;
				end
			end
			u2a_pkg::ST_EMIT: begin
				if (push && left_q == u2a_pkg::COUNT_W'(1)) begin
					state_nx = u2a_pkg::ST_IDLE;
				end
			end
			default: state_nx = u2a_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		number.ready = 1'b0;
		skip_shift   = 1'b0;
		push         = 1'b0;
		case (state_q)
			u2a_pkg::ST_IDLE: number.ready = 1'b1;
			u2a_pkg::ST_SKIP: skip_shift = (top_dig == 4'd0) && (ndig_q > u2a_pkg::LEFT_W'(1));
			u2a_pkg::ST_EMIT: push = take;
			default: ;
		endcase
	end

	assign accept     = number.valid && number.ready;
	assign conv_start = accept && (fmt == u2a_pkg::FMT_DEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u2a_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Load digits, drop leading zeros, then shift one digit out per transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			lower_q <= (fmt == u2a_pkg::FMT_HEX_LO) || (fmt == u2a_pkg::FMT_HEX_LX);
			if (fmt == u2a_pkg::FMT_HEX_UP) begin
				dig_q  <= u2a_pkg::DIG_BITS'(u2a_pkg::HEXN_BITS'(
					number.value[u2a_pkg::NARROW_WIDTH-1:0]))
					<< (u2a_pkg::DIG_BITS - u2a_pkg::HEXN_BITS);
				ndig_q <= u2a_pkg::LEFT_W'(u2a_pkg::HEXN_DIGITS);
			end else begin
				dig_q  <= u2a_pkg::DIG_BITS'(u2a_pkg::HEXW_BITS'(
					number.value[u2a_pkg::WIDE_WIDTH-1:0]))
					<< (u2a_pkg::DIG_BITS - u2a_pkg::HEXW_BITS);
				ndig_q <= u2a_pkg::LEFT_W'(u2a_pkg::HEXW_DIGITS);
			end
		end else if (state_q == u2a_pkg::ST_CONV && conv_done) begin
			dig_q  <= u2a_pkg::DIG_BITS'(bcd) << (u2a_pkg::DIG_BITS - u2a_pkg::BCD_W);
			ndig_q <= u2a_pkg::LEFT_W'(u2a_pkg::DEC_DIGITS);
		end else if (state_q == u2a_pkg::ST_SKIP) begin
			if (skip_shift) begin
				dig_q  <= dig_q << 4;
				ndig_q <= ndig_q - u2a_pkg::LEFT_W'(1);
			end else begin
				left_q <= total;
				tot_q  <= total;
			end
		end else if (push) begin
			dig_q  <= dig_q << 4;
			left_q <= left_q - u2a_pkg::COUNT_W'(1);
		end
	end

	assign res.character   = u2a_pkg::digit_char(top_dig, lower_q);
	assign res.last        = (left_q == u2a_pkg::COUNT_W'(1));
	assign res.digit_count = tot_q;

	u2a_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.data   (res),
		.take   (take),
		.digits (digits)
	);

endmodule

>>> rtl/core/u2a_checker.sv
`timescale 1ns / 1ps
`include "unsigned_to_ascii_digits_unit_macros.svh"
module u2a_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        number_valid,
	input logic                        number_ready,
	input logic                        digits_valid,
	input logic                        digits_ready,
	input logic [u2a_pkg::CHAR_W-1:0]  digits_character,
	input logic                        digits_last,
	input logic [u2a_pkg::COUNT_W-1:0] digits_count
);

	// A stalled result keeps its payload
	`U2A_ASSERT_NEXT(a_stall_hold, digits_valid && !digits_ready, digits_valid && $stable(digits_character) && $stable(digits_last) && $stable(digits_count), "stalled result changed")

	// Only digit characters leave the block
	`U2A_ASSERT_NOW(a_char_range, digits_valid, (digits_character >= 7'd48 && digits_character <= 7'd57) || (digits_character >= 7'd65 && digits_character <= 7'd70) || (digits_character >= 7'd97 && digits_character <= 7'd102), "character out of range")

	// A single-digit number is its own last character; counts stay legal
	`U2A_ASSERT_NOW(a_count_last, digits_valid && digits_count == 5'd1, digits_last, "one-digit result without last")
	`U2A_ASSERT_NOW(a_count_range, digits_valid, digits_count != 5'd0 && digits_count <= 5'd16, "digit count out of range")

	// The block works on one item at a time
	`U2A_ASSERT_NEXT(a_busy_after_take, number_valid && number_ready, !number_ready, "second item taken while busy")

endmodule

bind unsigned_to_ascii_digits_unit u2a_checker u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.number_valid     (number.valid),
	.number_ready     (number.ready),
	.digits_valid     (digits.valid),
	.digits_ready     (digits.ready),
	.digits_character (digits.character),
	.digits_last      (digits.last),
	.digits_count     (digits.digit_count)
);
